[sv/kec_pkg.sv]
// Shared key codes, operator codes, widths and control structures of the keypad calculator.
package kec_pkg;

	localparam int DATA_W = 32;
	localparam int KEY_W = 8;
	localparam int OP_W = 3;
	localparam int CNT_W = $clog2(DATA_W);

	localparam logic [KEY_W-1:0] KEY_PLUS  = 8'h2B;
	localparam logic [KEY_W-1:0] KEY_MINUS = 8'h2D;
	localparam logic [KEY_W-1:0] KEY_MUL   = 8'h2A;
	localparam logic [KEY_W-1:0] KEY_DIV   = 8'h2F;
	localparam logic [KEY_W-1:0] KEY_EQ    = 8'h3D;
	localparam logic [KEY_W-1:0] KEY_CLEAR = 8'h43;
	localparam logic [KEY_W-1:0] KEY_ZERO  = 8'h30;
	localparam logic [KEY_W-1:0] KEY_NINE  = 8'h39;

	localparam logic [OP_W-1:0] OP_NONE = 3'd0;
	localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
	localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
	localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
	localparam logic [OP_W-1:0] OP_DIV  = 3'd4;

	// Request from the key parser to the arithmetic unit.
	typedef struct packed {
		logic start;
		logic ack;
		logic [OP_W-1:0] op;
	} kec_alu_ctl_t;

	// Status returned by the arithmetic unit.
	typedef struct packed {
		logic busy;
		logic done;
	} kec_alu_sts_t;

	// Decimal accumulation: acc * 10 + digit, wrapping to the data width.
	function automatic logic [DATA_W-1:0] acc_digit(input logic [DATA_W-1:0] acc,
		input logic [3:0] digit);
		logic [DATA_W-1:0] sum;
		begin
			sum = (acc << 3) + (acc << 1) + {{(DATA_W-4){1'b0}}, digit};
			return sum;
		end
	endfunction

endpackage

[sv/kec_alu.sv]
// Iterative arithmetic unit: bit-serial add and subtract, shift-add multiply, restoring divide.
module kec_alu
	import kec_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  kec_alu_ctl_t      ctl,
	input  logic [DATA_W-1:0] opa,
	input  logic [DATA_W-1:0] opb,
	output kec_alu_sts_t      sts,
	output logic [DATA_W-1:0] result,
	output logic              div_zero
);

	localparam logic [1:0] AS_IDLE = 2'd0;
	localparam logic [1:0] AS_RUN  = 2'd1;
	localparam logic [1:0] AS_FIX  = 2'd2;
	localparam logic [1:0] AS_DONE = 2'd3;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

	logic [1:0]        ast_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [OP_W-1:0]   op_q;
	logic [DATA_W-1:0] a_q;
	logic [DATA_W-1:0] b_q;
	logic [DATA_W-1:0] acc_q;
	logic              carry_q;
	logic              neg_q;
	logic              dz_q;
	logic [DATA_W-1:0] result_q;

	logic [DATA_W-1:0] mag_a;
	logic [DATA_W-1:0] mag_b;
	logic [DATA_W-1:0] rem_shift;
	logic [DATA_W:0]   trial;
	logic              sum_bit;
	logic              sum_carry;

	assign mag_a = opa[DATA_W-1] ? (~opa + DATA_W'(1)) : opa;
	assign mag_b = opb[DATA_W-1] ? (~opb + DATA_W'(1)) : opb;
	assign rem_shift = {acc_q[DATA_W-2:0], a_q[DATA_W-1]};
	assign trial = {1'b0, rem_shift} - {1'b0, b_q};
	assign sum_bit = a_q[0] ^ b_q[0] ^ carry_q;
	assign sum_carry = (a_q[0] & b_q[0]) | (a_q[0] & carry_q) | (b_q[0] & carry_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ast_q <= AS_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (ast_q)
				AS_IDLE: begin
					cnt_q <= '0;
					if (ctl.start) begin
						ast_q <= AS_RUN;
					end
				end
				AS_RUN: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_LAST) begin
						ast_q <= AS_FIX;
					end
				end
				AS_FIX: ast_q <= AS_DONE;
				AS_DONE: begin
					if (ctl.ack) begin
						ast_q <= AS_IDLE;
					end
				end
				default: ast_q <= AS_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ast_q == AS_IDLE && ctl.start) begin
			op_q    <= ctl.op;
			acc_q   <= '0;
			neg_q   <= opa[DATA_W-1] ^ opb[DATA_W-1];
			dz_q    <= (ctl.op == OP_DIV) && (opb == '0);
			carry_q <= (ctl.op == OP_SUB);
			if (ctl.op == OP_DIV) begin
				a_q <= mag_a;
				b_q <= mag_b;
			end else if (ctl.op == OP_SUB) begin
				a_q <= opa;
				b_q <= ~opb;
			end else begin
				a_q <= opa;
				b_q <= opb;
			end
		end else if (ast_q == AS_RUN) begin
			unique case (op_q)
				OP_ADD, OP_SUB: begin
					// One sum bit per cycle enters from the top; after a full pass
					// a_q holds the sum.
					a_q     <= {sum_bit, a_q[DATA_W-1:1]};
					b_q     <= {1'b0, b_q[DATA_W-1:1]};
					carry_q <= sum_carry;
				end
				OP_MUL: begin
					if (b_q[0]) begin
						acc_q <= acc_q + a_q;
					end
					a_q <= {a_q[DATA_W-2:0], 1'b0};
					b_q <= {1'b0, b_q[DATA_W-1:1]};
				end
				OP_DIV: begin
					// Restoring step: the dividend shifts out of a_q while the
					// quotient bits shift in behind it.
					if (!trial[DATA_W]) begin
						acc_q <= trial[DATA_W-1:0];
						a_q   <= {a_q[DATA_W-2:0], 1'b1};
					end else begin
						acc_q <= rem_shift;
						a_q   <= {a_q[DATA_W-2:0], 1'b0};
					end
				end
				default: begin
					a_q <= a_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ast_q == AS_FIX) begin
			unique case (op_q)
				OP_ADD, OP_SUB: result_q <= a_q;
				OP_MUL:         result_q <= acc_q;
				OP_DIV: begin
					if (dz_q) begin
						result_q <= '0;
					end else if (neg_q) begin
						result_q <= ~a_q + DATA_W'(1);
					end else begin
						result_q <= a_q;
					end
				end
				default: result_q <= '0;
			endcase
		end
	end

	assign sts.busy = (ast_q != AS_IDLE);
	assign sts.done = (ast_q == AS_DONE);
	assign result = result_q;
	assign div_zero = dz_q;

endmodule

[sv/keypad_expression_calculator_core.sv]
// Top level of the keypad calculator: key parser, operand registers and result register.
// The block takes ASCII key codes one transfer at a time and builds a two-operand
// expression: the first operand is parsed like atoi (optional sign, then digits,
// frozen at the first other key), the last of + - * / entered is the operator, and
// the digits after it form the second operand. A '=' key starts the arithmetic unit
// and produces one result transfer carrying the 32-bit wrapping sum, difference or
// product, or the quotient truncated toward zero; division by zero gives value 0 with
// divide_by_zero set. Both '=' and 'C' clear the expression; every other key only
// updates the expression and produces no result. A '=' key occupies the block through
// a start step, the iterations of the shared serial arithmetic unit, a sign and select
// step and the load into the result register, plus any time the result waits for the
// result register to empty; keys are not taken during that time. The finished result
// sits in its own register, so keys are taken again while it waits.
module keypad_expression_calculator_core
	import kec_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [KEY_W-1:0]         key,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] value,
	output logic                     divide_by_zero
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_BUSY = 1'b1;

	localparam logic [1:0] PH_START  = 2'd0;
	localparam logic [1:0] PH_SIGN   = 2'd1;
	localparam logic [1:0] PH_DIGITS = 2'd2;
	localparam logic [1:0] PH_FROZEN = 2'd3;

	logic              state_q;

	// Expression state, updated on every accepted key.
	logic [DATA_W-1:0] first_q;
	logic [1:0]        phase_q;
	logic              first_neg_q;
	logic [DATA_W-1:0] second_q;
	logic              second_frozen_q;
	logic [OP_W-1:0]   pend_op_q;
	logic              op_first_key_q;
	logic              any_key_q;

	logic [DATA_W-1:0] first_d;
	logic [1:0]        phase_d;
	logic              first_neg_d;
	logic [DATA_W-1:0] second_d;
	logic              second_frozen_d;
	logic [OP_W-1:0]   pend_op_d;
	logic              op_first_key_d;
	logic              any_key_d;

	logic              out_valid_q;
	logic [DATA_W-1:0] value_q;
	logic              dz_q;

	logic              accept;
	logic              is_digit;
	logic [3:0]        digit;
	logic [OP_W-1:0]   key_op;
	logic [DATA_W-1:0] opa;
	logic              load_out;

	kec_alu_ctl_t      alu_ctl;
	kec_alu_sts_t      alu_sts;
	logic [DATA_W-1:0] alu_result;
	logic              alu_dz;

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;

	assign is_digit = (key >= KEY_ZERO) && (key <= KEY_NINE);
	assign digit = is_digit ? 4'(key - KEY_ZERO) : 4'd0;

	always_comb begin
		unique if (key == KEY_PLUS) begin
			key_op = OP_ADD;
		end else if (key == KEY_MINUS) begin
			key_op = OP_SUB;
		end else if (key == KEY_MUL) begin
			key_op = OP_MUL;
		end else if (key == KEY_DIV) begin
			key_op = OP_DIV;
		end else begin
			key_op = OP_NONE;
		end
	end

	// Next expression state for the key on the input.
	always_comb begin
		first_d         = first_q;
		phase_d         = phase_q;
		first_neg_d     = first_neg_q;
		second_d        = second_q;
		second_frozen_d = second_frozen_q;
		pend_op_d       = pend_op_q;
		op_first_key_d  = op_first_key_q;
		any_key_d       = 1'b1;
		if (key == KEY_CLEAR || key == KEY_EQ) begin
			first_d         = '0;
			phase_d         = PH_START;
			first_neg_d     = 1'b0;
			second_d        = '0;
			second_frozen_d = 1'b0;
			pend_op_d       = OP_NONE;
			op_first_key_d  = 1'b0;
			any_key_d       = 1'b0;
		end else begin
			// The first operand follows atoi: a sign is legal only as the very
			// first key, and any non-digit afterwards freezes it.
			if (phase_q == PH_START) begin
				if (key == KEY_PLUS || key == KEY_MINUS) begin
					first_neg_d = (key == KEY_MINUS);
					phase_d     = PH_SIGN;
				end else if (is_digit) begin
					first_d = acc_digit(first_q, digit);
					phase_d = PH_DIGITS;
				end else begin
					phase_d = PH_FROZEN;
				end
			end else if (phase_q != PH_FROZEN) begin
				if (is_digit) begin
					first_d = acc_digit(first_q, digit);
					phase_d = PH_DIGITS;
				end else begin
					phase_d = PH_FROZEN;
				end
			end
			// Each operator restarts the second operand; the last one wins.
			if (key_op != OP_NONE) begin
				pend_op_d       = key_op;
				op_first_key_d  = !any_key_q;
				second_d        = '0;
				second_frozen_d = 1'b0;
			end else if (!second_frozen_q) begin
				if (is_digit) begin
					second_d = acc_digit(second_q, digit);
				end else begin
					second_frozen_d = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q         <= '0;
			phase_q         <= PH_START;
			first_neg_q     <= 1'b0;
			second_q        <= '0;
			second_frozen_q <= 1'b0;
			pend_op_q       <= OP_NONE;
			op_first_key_q  <= 1'b0;
			any_key_q       <= 1'b0;
		end else if (accept) begin
			first_q         <= first_d;
			phase_q         <= phase_d;
			first_neg_q     <= first_neg_d;
			second_q        <= second_d;
			second_frozen_q <= second_frozen_d;
			pend_op_q       <= pend_op_d;
			op_first_key_q  <= op_first_key_d;
			any_key_q       <= any_key_d;
		end
	end

	// A leading operator that is never followed by another leaves the first
	// operand at zero; otherwise the sign is applied by two's complement.
	always_comb begin
		if (op_first_key_q) begin
			opa = '0;
		end else if (first_neg_q) begin
			opa = ~first_q + DATA_W'(1);
		end else begin
			opa = first_q;
		end
	end

	// The result register takes the arithmetic result once it is free or being
	// emptied in the same cycle.
	assign load_out = (state_q == ST_BUSY) && alu_sts.done && (!out_valid_q || out_ready);

	assign alu_ctl.start = accept && (key == KEY_EQ);
	assign alu_ctl.ack   = load_out;
	assign alu_ctl.op    = pend_op_q;

	kec_alu u_alu (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (alu_ctl),
		.opa      (opa),
		.opb      (second_q),
		.sts      (alu_sts),
		.result   (alu_result),
		.div_zero (alu_dz)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (alu_ctl.start) begin
						state_q <= ST_BUSY;
					end
				end
				ST_BUSY: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			value_q <= alu_result;
			dz_q    <= alu_dz;
		end
	end

	assign out_valid = out_valid_q;
	assign value = value_q;
	assign divide_by_zero = dz_q;

	// The arithmetic unit is only started when it is free.
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		alu_ctl.start |-> !alu_sts.busy)
		else $error("arithmetic unit started while busy");

	// A finished result only exists while the parser waits for it.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		alu_sts.done |-> (state_q == ST_BUSY))
		else $error("arithmetic result with parser idle");

	// An equals key moves the parser into the waiting state.
	a_eq_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && key == KEY_EQ) |=> (state_q == ST_BUSY) && alu_sts.busy)
		else $error("equals key did not start evaluation");

	// Division by zero always reports a zero value.
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && divide_by_zero) |-> (value == '0))
		else $error("division by zero with nonzero value");

	// The expression is cleared after each evaluation.
	a_eq_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && key == KEY_EQ) |=> (pend_op_q == OP_NONE) && !any_key_q)
		else $error("expression not cleared after equals");

endmodule
